@@ rtl/core/frcd_pkg.sv @@
// ============================================================================
// frcd_pkg: shared types and constants of the fraction reducer
// Holds the mode codes, result code limits and the sequencer state type.
// ============================================================================
`default_nettype none

package frcd_pkg;

    localparam int COUNT_W = 8;

    // Mode register codes
    localparam logic MODE_COUNT  = 1'b0;
    localparam logic MODE_REDUCE = 1'b1;

    // Divisor count codes
    localparam logic signed [COUNT_W-1:0] COUNT_NONE = -8'sd1;
    localparam logic signed [COUNT_W-1:0] COUNT_MAX  = 8'sd127;

    typedef enum logic [9:0] {
        S_IDLE        = 10'b0000000001,
        S_GCD_ISSUE   = 10'b0000000010,
        S_GCD_WAIT    = 10'b0000000100,
        S_TRIAL_ISSUE = 10'b0000001000,
        S_TRIAL_WAIT  = 10'b0000010000,
        S_QN_ISSUE    = 10'b0000100000,
        S_QN_WAIT     = 10'b0001000000,
        S_QD_ISSUE    = 10'b0010000000,
        S_QD_WAIT     = 10'b0100000000,
        S_DONE        = 10'b1000000000
    } state_t;

endpackage

`default_nettype wire

@@ rtl/core/frcd_channels.sv @@
// ============================================================================
// frcd_channels: valid/ready channels of the fraction reducer
// Input item channel, result channel and mode write channel.
// ============================================================================
`default_nettype none

interface frcd_in_if #(
    parameter int W = 16
);
    logic         valid;
    logic         ready;
    logic [W-1:0] numerator;
    logic [W-1:0] denominator;

    modport source (output valid, numerator, denominator, input ready);
    modport sink   (input valid, numerator, denominator, output ready);
endinterface

interface frcd_out_if #(
    parameter int W = 16
);
    logic                                 valid;
    logic                                 ready;
    logic signed [frcd_pkg::COUNT_W-1:0]  divisor_count;
    logic [W-1:0]                         reduced_numerator;
    logic [W-1:0]                         reduced_denominator;

    modport source (output valid, divisor_count, reduced_numerator, reduced_denominator,
                    input ready);
    modport sink   (input valid, divisor_count, reduced_numerator, reduced_denominator,
                    output ready);
endinterface

interface frcd_cfg_if;
    logic valid;
    logic ready;
    logic mode;

    modport source (output valid, mode, input ready);
    modport sink   (input valid, mode, output ready);
endinterface

`default_nettype wire

@@ rtl/core/frcd_div.sv @@
// ============================================================================
// frcd_div: shared restoring divider
// Produces quotient and remainder one bit per cycle.
// ============================================================================
`default_nettype none

module frcd_div #(
    parameter int W = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quotient,
    output logic [W-1:0]      remainder
);
    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     dvs_reg, dvs_next;

    logic [W:0]       shifted;
    logic [W+1:0]     diff;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign fits    = ~diff[W+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // subtract when the partial remainder holds the divisor
            rem_next = fits ? diff[W-1:0] : shifted[W-1:0];
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

@@ rtl/core/frcd_seq.sv @@
// ============================================================================
// frcd_seq: sequencer of the fraction reducer
// Runs Euclid, trial division and the final quotients on the shared divider.
// ============================================================================
`default_nettype none

module frcd_seq #(
    parameter int W = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [W-1:0]                        num_in,
    input  wire logic [W-1:0]                        den_in,
    input  wire logic                                mode,
    output logic                                     res_valid,
    input  wire logic                                res_ready,
    output logic signed [frcd_pkg::COUNT_W-1:0]      res_count,
    output logic [W-1:0]                             res_num,
    output logic [W-1:0]                             res_den
);
    import frcd_pkg::*;

    localparam int TOT_W = W / 2 + 2;
    localparam int CW    = (TOT_W > COUNT_W) ? TOT_W : COUNT_W;

    state_t           state_reg, state_next;
    logic [W-1:0]     num_reg, num_next;
    logic [W-1:0]     den_reg, den_next;
    logic             mode_reg, mode_next;
    logic             zero_reg, zero_next;
    logic [W-1:0]     x_reg, x_next;
    logic [W-1:0]     y_reg, y_next;
    logic [W-1:0]     trial_reg, trial_next;
    logic [W:0]       sq_reg, sq_next;
    logic [TOT_W-1:0] tot_reg, tot_next;
    logic [W-1:0]     qn_reg, qn_next;
    logic [W-1:0]     qd_reg, qd_next;

    logic             div_start;
    logic [W-1:0]     div_dividend;
    logic [W-1:0]     div_divisor;
    logic             div_done;
    logic [W-1:0]     div_quo;
    logic [W-1:0]     div_rem;

    logic [W:0]       sq_step;
    logic [CW-1:0]    cnt_ext;

    frcd_div #(.W(W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // (d+1)^2 = d^2 + 2d + 1
    assign sq_step = sq_reg + {trial_reg, 1'b1};

    always_comb
    begin
        state_next   = state_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        mode_next    = mode_reg;
        zero_next    = zero_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        trial_next   = trial_reg;
        sq_next      = sq_reg;
        tot_next     = tot_reg;
        qn_next      = qn_reg;
        qd_next      = qd_reg;
        div_start    = 1'b0;
        div_dividend = x_reg;
        div_divisor  = y_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    num_next   = num_in;
                    den_next   = den_in;
                    mode_next  = mode;
                    x_next     = num_in;
                    y_next     = den_in;
                    zero_next  = (num_in == '0) || (den_in == '0);
                    state_next = ((num_in == '0) || (den_in == '0)) ? S_DONE : S_GCD_ISSUE;
                end
            end
            S_GCD_ISSUE:
            begin
                div_start  = 1'b1;
                state_next = S_GCD_WAIT;
            end
            S_GCD_WAIT:
            begin
                if (div_done)
                begin
                    x_next = y_reg;
                    y_next = div_rem;
                    if (div_rem == '0)
                    begin
                        // x now holds the gcd
                        if (mode_reg == MODE_COUNT)
                        begin
                            trial_next = W'(1);
                            sq_next    = (W+1)'(1);
                            tot_next   = '0;
                            state_next = S_TRIAL_ISSUE;
                        end
                        else
                        begin
                            state_next = S_QN_ISSUE;
                        end
                    end
                    else
                    begin
                        state_next = S_GCD_ISSUE;
                    end
                end
            end
            S_TRIAL_ISSUE:
            begin
                div_start    = 1'b1;
                div_dividend = x_reg;
                div_divisor  = trial_reg;
                state_next   = S_TRIAL_WAIT;
            end
            S_TRIAL_WAIT:
            begin
                if (div_done)
                begin
                    if (div_rem == '0)
                    begin
                        tot_next = tot_reg +
                                   ((sq_reg == {1'b0, x_reg}) ? TOT_W'(1) : TOT_W'(2));
                    end
                    trial_next = trial_reg + W'(1);
                    sq_next    = sq_step;
                    state_next = (sq_step > {1'b0, x_reg}) ? S_DONE : S_TRIAL_ISSUE;
                end
            end
            S_QN_ISSUE:
            begin
                div_start    = 1'b1;
                div_dividend = num_reg;
                div_divisor  = x_reg;
                state_next   = S_QN_WAIT;
            end
            S_QN_WAIT:
            begin
                if (div_done)
                begin
                    qn_next    = div_quo;
                    state_next = S_QD_ISSUE;
                end
            end
            S_QD_ISSUE:
            begin
                div_start    = 1'b1;
                div_dividend = den_reg;
                div_divisor  = x_reg;
                state_next   = S_QD_WAIT;
            end
            S_QD_WAIT:
            begin
                if (div_done)
                begin
                    qd_next    = div_quo;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        den_reg   <= den_next;
        mode_reg  <= mode_next;
        zero_reg  <= zero_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        trial_reg <= trial_next;
        sq_reg    <= sq_next;
        tot_reg   <= tot_next;
        qn_reg    <= qn_next;
        qd_reg    <= qd_next;
    end

    // common divisors above one = total divisors of the gcd minus one
    assign cnt_ext = CW'(tot_reg) - CW'(1);

    always_comb
    begin
        res_count = '0;
        res_num   = '0;
        res_den   = '0;
        if (mode_reg == MODE_COUNT)
        begin
            if (zero_reg || (cnt_ext == '0))
            begin
                res_count = COUNT_NONE;
            end
            else if (cnt_ext > CW'(COUNT_MAX))
            begin
                res_count = COUNT_MAX;
            end
            else
            begin
                res_count = cnt_ext[COUNT_W-1:0];
            end
        end
        else if (zero_reg)
        begin
            res_num = num_reg;
            res_den = den_reg;
        end
        else
        begin
            res_num = qn_reg;
            res_den = qd_reg;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

endmodule

`default_nettype wire

@@ rtl/core/fraction_reducer_common_divisors_unit.sv @@
// ============================================================================
// fraction_reducer_common_divisors_unit: fraction reducer and divisor counter
// Counts the common divisors above one of two values, or reduces their
// fraction to lowest terms, on one shared bit-serial divider.
// ============================================================================
//
//  channel   role   payload                                            handshake
//  -------   ----   -------------------------------------------------  ---------
//  items     sink   numerator, denominator (VALUE_WIDTH bits each)     valid/ready
//  results   source divisor_count (8b signed), reduced_numerator,      valid/ready
//                   reduced_denominator (VALUE_WIDTH bits each)
//  cfg       sink   mode (0 count, 1 reduce)                           valid/ready
//
//  Every division runs on one restoring divider, started from an issue state
//  and picked up in a wait state of the sequencer. Count mode: (Euclid steps +
//  floor(sqrt(gcd))) divisions; reduce mode: Euclid steps + 2 divisions.
//  A zero operand skips the divider and goes from idle straight to done.
//  One transaction is in work at a time; items.ready stays low until the result
//  moves into the output register, which holds it through any results stall.
//  rst_n clears the sequencer, the output valid and mode (to count).
//
`default_nettype none

module fraction_reducer_common_divisors_unit #(
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    frcd_in_if.sink    items,
    frcd_out_if.source results,
    frcd_cfg_if.sink   cfg
);
    import frcd_pkg::*;

    logic                        mode_reg;
    logic                        out_valid_reg, out_valid_next;
    logic signed [COUNT_W-1:0]   count_reg;
    logic [VALUE_WIDTH-1:0]      rnum_reg;
    logic [VALUE_WIDTH-1:0]      rden_reg;

    logic                        res_valid;
    logic                        res_ready;
    logic signed [COUNT_W-1:0]   res_count;
    logic [VALUE_WIDTH-1:0]      res_num;
    logic [VALUE_WIDTH-1:0]      res_den;

    // Mode register: always ready; the user must see that it is written only while the block is idle
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_COUNT;
        end
        else if (cfg.valid)
        begin
            mode_reg <= cfg.mode;
        end
    end

    frcd_seq #(.W(VALUE_WIDTH)) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_ready  (items.ready),
        .num_in    (items.numerator),
        .den_in    (items.denominator),
        .mode      (mode_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_count (res_count),
        .res_num   (res_num),
        .res_den   (res_den)
    );

    // Output register: take a new result when empty or being drained
    assign res_ready = !out_valid_reg || results.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the payload until the next result moves in
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            count_reg <= res_count;
            rnum_reg  <= res_num;
            rden_reg  <= res_den;
        end
    end

    assign results.valid               = out_valid_reg;
    assign results.divisor_count       = count_reg;
    assign results.reduced_numerator   = rnum_reg;
    assign results.reduced_denominator = rden_reg;

`ifndef SYNTHESIS
    // An accepted item keeps the sequencer busy for at least the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (items.valid && items.ready) |=> !items.ready)
        else $error("item accepted while the sequencer stayed idle");

    // A result handed over always shows up on the results channel
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> results.valid)
        else $error("result handed over but output register empty");

    // The sequencer never offers a result while it is also ready for input
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !items.ready)
        else $error("sequencer holds a result and accepts input at once");
`endif

endmodule

`default_nettype wire

@@ sim/frcd_reduction_checker.sv @@
// ============================================================================
// frcd_reduction_checker: result predictor and comparator
// Tracks the mode register, predicts one result per accepted fraction and
// compares every returned result, field by field, in arrival order.
// ============================================================================

module frcd_reduction_checker
    import frcd_pkg::*;
#(
    parameter int W = 16
) (
    input  logic clk,
    input  logic rst_n,
    frcd_in_if   items,
    frcd_out_if  results,
    frcd_cfg_if  cfg,
    output int   mismatches,
    output int   awaiting
);

    typedef struct packed {
        logic signed [COUNT_W-1:0] divisor_count;
        logic [W-1:0]              num;
        logic [W-1:0]              den;
    } fraction_result_t;

    logic             cur_mode;
    fraction_result_t expected_results[$];

    function automatic logic [W-1:0] greatest_common_divisor(input logic [W-1:0] a,
                                                             input logic [W-1:0] b);
        logic [W-1:0] x;
        logic [W-1:0] y;
        logic [W-1:0] r;
        x = a;
        y = b;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    // Divisors of g other than one, by trial division up to sqrt(g), capped at COUNT_MAX
    function automatic logic signed [COUNT_W-1:0] divisors_above_one(input logic [W-1:0] g);
        longint unsigned d;
        int unsigned     total;
        total = 0;
        for (d = 1; d * d <= g; d++)
            if (g % d == 0)
                total += (d * d == g) ? 1 : 2;
        total = total - 1;
        if (total > COUNT_MAX)
            total = COUNT_MAX;
        return total[COUNT_W-1:0];
    endfunction

    function automatic fraction_result_t predict_fraction(input logic m,
                                                          input logic [W-1:0] a,
                                                          input logic [W-1:0] b);
        fraction_result_t r;
        logic [W-1:0]     g;
        logic             both_set;
        both_set = (a != 0) && (b != 0);
        g = both_set ? greatest_common_divisor(a, b) : '0;
        r = '0;
        if (m == MODE_COUNT) begin
            if (!both_set || g == 1)
                r.divisor_count = COUNT_NONE;
            else
                r.divisor_count = divisors_above_one(g);
        end
        else if (both_set) begin
            r.num = a / g;
            r.den = b / g;
        end
        else begin
            r.num = a;
            r.den = b;
        end
        return r;
    endfunction

    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        fraction_result_t oldest;
        if (!rst_n) begin
            cur_mode <= MODE_COUNT;
            expected_results.delete();
            mismatches = 0;
            awaiting = 0;
        end
        else begin
            if (cfg.valid && cfg.ready)
                cur_mode <= cfg.mode;
            if (results.valid && results.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing pending: expected none, actual %0d %0d %0d",
                             $time, results.divisor_count, results.reduced_numerator,
                             results.reduced_denominator);
                    mismatches++;
                end
                else begin
                    oldest = expected_results.pop_front();
                    check_field("divisor_count", oldest.divisor_count, results.divisor_count);
                    check_field("reduced_numerator", oldest.num, results.reduced_numerator);
                    check_field("reduced_denominator", oldest.den,
                                results.reduced_denominator);
                end
            end
            if (items.valid && items.ready)
                expected_results.push_back(predict_fraction(cur_mode, items.numerator,
                                                            items.denominator));
            awaiting = expected_results.size();
        end
    end

endmodule

@@ sim/tb_fraction_reducer_common_divisors_unit.sv @@
// ============================================================================
// tb_fraction_reducer_common_divisors_unit: testbench top of the reducer
// Drives fractions and mode writes, throttles the result side, and reports
// the verdict from the failure count of the reduction checker.
// ============================================================================

module tb_fraction_reducer_common_divisors_unit;
    import frcd_pkg::*;

    localparam int VALUE_WIDTH = 16;
    localparam int PHASE_ITEMS = 28;
    // Long results stall, long enough to back the block up into the items side
    localparam int LONG_HOLD   = 12000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   mismatches;
    int   awaiting;
    // Drop all idling on both sides (last part of the run)
    bit   quiet = 1'b0;
    // Ask the result side for one long stall
    bit   hold_results = 1'b0;

    frcd_in_if  #(.W(VALUE_WIDTH)) items ();
    frcd_out_if #(.W(VALUE_WIDTH)) results ();
    frcd_cfg_if                    cfg ();

    always #2 clk = ~clk;

    fraction_reducer_common_divisors_unit #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .cfg     (cfg)
    );

    frcd_reduction_checker #(.W(VALUE_WIDTH)) reduction_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .results    (results),
        .cfg        (cfg),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    // Hard stop: several times the slowest legal run (every item at the
    // worst-case count latency plus full stalls on both sides)
    initial
    begin : watchdog
        #16000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: alternate random ready bursts, or hold ready low once for the
    // long stall when asked, while the item side keeps offering.
    initial
    begin : result_side
        int unsigned span;
        results.ready <= 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever begin
            if (hold_results) begin
                results.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_results = 1'b0;
            end
            else begin
                span = $urandom_range(1, 16);
                results.ready <= quiet || ($urandom_range(0, 3) != 0);
                repeat (span) @(posedge clk);
            end
        end
    end

    // Offer one fraction, maybe after an idle burst; return at the edge
    // where the transaction is accepted.
    task automatic send_fraction(input logic [VALUE_WIDTH-1:0] num,
                                 input logic [VALUE_WIDTH-1:0] den);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            items.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        items.valid       <= 1'b1;
        items.numerator   <= num;
        items.denominator <= den;
        do @(posedge clk); while (items.ready !== 1'b1);
    endtask

    // Write the mode register; only called while nothing is in flight
    task automatic write_mode(input logic m);
        cfg.valid <= 1'b1;
        cfg.mode  <= m;
        do @(posedge clk); while (cfg.ready !== 1'b1);
        cfg.valid <= 1'b0;
    endtask

    // Stop offering and wait until every predicted result has come back.
    // Sample the pending count at the falling edge, after the checker updates.
    task automatic wait_drained();
        items.valid <= 1'b0;
        do @(negedge clk); while (awaiting != 0);
        @(posedge clk);
    endtask

    // Edge values and special cases, run once per mode
    task automatic send_corner_fractions();
        send_fraction(16'd1, 16'd1);           // coprime, smallest
        send_fraction(16'hFFFF, 16'hFFFF);     // largest gcd, longest trial loop
        send_fraction(16'd55440, 16'd55440);   // most divisors in 16 bits
        send_fraction(16'd65520, 16'd55440);   // rich shared factor
        send_fraction(16'd12, 16'd18);
        send_fraction(16'd7, 16'd13);          // coprime primes
        send_fraction(16'hFFFF, 16'd1);
        send_fraction(16'd1, 16'hFFFF);
        send_fraction(16'h8000, 16'hC000);     // power-of-two gcd
        send_fraction(16'd0, 16'd9);           // zero numerator: no gcd
        send_fraction(16'd9, 16'd0);           // zero denominator: no gcd
        send_fraction(16'd0, 16'd0);
    endtask

    // Mostly fractions with a real common factor, so that count mode does
    // actual trial division; the rest is plain random, equal pairs and zeros.
    task automatic send_random_fractions(input int count);
        int unsigned rich[5];
        int unsigned kind;
        int unsigned g;
        int unsigned num;
        int unsigned den;
        rich = '{720, 5040, 27720, 55440, 65520};
        repeat (count) begin
            kind = $urandom_range(0, 9);
            if (kind <= 4) begin
                g = ($urandom_range(0, 7) == 0) ? $urandom_range(256, 65535)
                                                : $urandom_range(2, 255);
                num = g * $urandom_range(1, 65535 / g);
                den = g * $urandom_range(1, 65535 / g);
            end
            else if (kind == 5) begin
                g = rich[$urandom_range(0, 4)];
                num = g * $urandom_range(1, 65535 / g);
                den = g * $urandom_range(1, 65535 / g);
            end
            else if (kind <= 7) begin
                num = $urandom_range(1, 65535);
                den = $urandom_range(1, 65535);
            end
            else if (kind == 8) begin
                num = $urandom_range(1, 65535);
                den = num;
            end
            else begin
                // Zero on one or both sides
                num = $urandom_range(0, 1) ? 0 : $urandom_range(1, 65535);
                den = (num != 0 || $urandom_range(0, 1)) ? 0 : $urandom_range(1, 65535);
            end
            send_fraction(num[VALUE_WIDTH-1:0], den[VALUE_WIDTH-1:0]);
        end
    endtask

    initial
    begin : stimulus
        items.valid       <= 1'b0;
        items.numerator   <= '0;
        items.denominator <= '0;
        cfg.valid         <= 1'b0;
        cfg.mode          <= MODE_COUNT;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: corners in both modes
        write_mode(MODE_COUNT);
        send_corner_fractions();
        wait_drained();
        write_mode(MODE_REDUCE);
        send_corner_fractions();
        wait_drained();

        // Random: first phase also stalls the result side for a long stretch
        hold_results = 1'b1;
        write_mode(MODE_COUNT);
        send_random_fractions(PHASE_ITEMS);
        wait_drained();

        write_mode(MODE_REDUCE);
        send_random_fractions(PHASE_ITEMS);
        wait_drained();

        write_mode(MODE_COUNT);
        send_random_fractions(PHASE_ITEMS);
        wait_drained();

        // Last phase at full rate on both sides
        quiet = 1'b1;
        write_mode(MODE_REDUCE);
        send_random_fractions(PHASE_ITEMS);
        wait_drained();

        repeat (64) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/frcd_pkg.sv
rtl/core/frcd_channels.sv
rtl/core/frcd_div.sv
rtl/core/frcd_seq.sv
rtl/core/fraction_reducer_common_divisors_unit.sv
sim/frcd_reduction_checker.sv
sim/tb_fraction_reducer_common_divisors_unit.sv
